// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the hash map block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define LPHM_ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lphm: concurrent assertion failed");

// Same, on the block clock and reset.
`define LPHM_ASSERT(lbl, prop) \
  `LPHM_ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

// ===== sv/lphm_pkg.sv =====
// Types and constants shared by the hash map modules.
package lphm_pkg;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } lphm_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_KEY = 2'd1,
    STATUS_FULL    = 2'd2
  } lphm_status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_RESP
  } lphm_state_e;

  // One table slot; a zero key marks an empty slot.
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
  } lphm_entry_t;

  typedef struct packed {
    logic         found;
    logic [63:0]  read_value;
    lphm_status_e status;
  } lphm_result_t;

endpackage

// ===== sv/lphm_mem.sv =====
// Slot memory: one write port, one read port with registered read data.
module lphm_mem import lphm_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output lphm_entry_t      rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  lphm_entry_t      wr_data_i
);

  lphm_entry_t ram_q [TABLE_ENTRIES];
  lphm_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ram_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= ram_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/lphm_ctrl.sv =====
// Probe sequencer: clear pass, linear probing, read-modify-write of slots.
module lphm_ctrl import lphm_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_PROBES    = 8,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  input  logic [63:0]      lookup_key_i,
  input  logic [63:0]      put_value_i,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output lphm_result_t     res_o,
  output logic             mem_rd_en_o,
  output logic [IDX_W-1:0] mem_rd_addr_o,
  input  lphm_entry_t      mem_rd_data_i,
  output logic             mem_wr_en_o,
  output logic [IDX_W-1:0] mem_wr_addr_o,
  output lphm_entry_t      mem_wr_data_o
);

  localparam int CNT_W = (MAX_PROBES > 0) ? $clog2(MAX_PROBES + 1) : 1;
  localparam logic [IDX_W-1:0] MASK      = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(MAX_PROBES);

  lphm_state_e      state_q, state_d;
  lphm_cmd_e        cmd_q, cmd_d;
  logic [63:0]      key_q, key_d;
  logic [63:0]      val_q, val_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  lphm_result_t     res_q, res_d;

  logic             key_zero;
  logic [IDX_W-1:0] start_idx;
  logic [IDX_W-1:0] next_idx;
  logic             slot_empty;
  logic             slot_hit;
  logic             probes_done;
  logic             is_put;
  logic             do_insert;

  assign key_zero    = (lookup_key_i == 64'd0);
  assign start_idx   = lookup_key_i[IDX_W-1:0] & MASK;
  assign next_idx    = (idx_q + IDX_W'(1)) & MASK;
  assign slot_empty  = (mem_rd_data_i.key == 64'd0);
  assign slot_hit    = (mem_rd_data_i.key == key_q);
  assign probes_done = (cnt_q == LAST_PROBE);
  assign is_put      = (cmd_q == CMD_PUT);
  assign do_insert   = is_put && (val_q != 64'd0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = key_zero ? ST_RESP : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (slot_empty || slot_hit || probes_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshake and memory ports
  always_comb begin
    in_stall_o    = 1'b1;
    res_valid_o   = 1'b0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = start_idx;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = idx_q;
    mem_wr_data_o = '{key: key_q, value: val_q};
    case (state_q)
      ST_CLEAR: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = clr_q;
        mem_wr_data_o = '{key: 64'd0, value: 64'd0};
      end
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        mem_rd_en_o = in_valid_i && !key_zero;
      end
      ST_PROBE: begin
        mem_rd_addr_o = next_idx;
        mem_rd_en_o   = !(slot_empty || slot_hit || probes_done);
        mem_wr_en_o   = (slot_empty && do_insert) || (!slot_empty && slot_hit && is_put);
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath registers
  always_comb begin
    cmd_d = cmd_q;
    key_d = key_q;
    val_d = val_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    res_d = res_q;
    case (state_q)
      ST_IDLE: begin
        cmd_d = lphm_cmd_e'(command_i);
        key_d = lookup_key_i;
        val_d = put_value_i;
        idx_d = start_idx;
        cnt_d = '0;
        res_d = '{found: 1'b0, read_value: 64'd0, status: STATUS_BAD_KEY};
      end
      ST_PROBE: begin
        idx_d = next_idx;
        cnt_d = cnt_q + CNT_W'(1);
        if (slot_empty) begin
          res_d = '{found: 1'b0, read_value: 64'd0, status: STATUS_OK};
        end else if (slot_hit) begin
          res_d = '{found: 1'b1, read_value: mem_rd_data_i.value, status: STATUS_OK};
        end else begin
          res_d = '{found: 1'b0, read_value: 64'd0,
                    status: do_insert ? STATUS_FULL : STATUS_OK};
        end
      end
      default: ;
    endcase
  end

  assign clr_d = (state_q == ST_CLEAR) ? clr_q + IDX_W'(1) : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    key_q <= key_d;
    val_q <= val_d;
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== sv/linear_probe_hash_map.sv =====
// Top level of the linear-probing hash map: sequencer, slot memory, output register.
//
// Input channel (in_valid_i / in_stall_o): one transaction is a get (command 0) or put
// (command 1) of a 64-bit key; put_value_i is the value a put stores. Key zero is
// refused with status 1 and leaves the table alone.
// Output channel (out_valid_o / out_stall_i): one result transaction per input
// transaction, in order: found, the value held before the operation, and status
// (0 ok, 1 zero key, 2 put could not find a free slot within the probe window).
// Each transaction probes slots key AND (TABLE_ENTRIES-1) onward, one synchronous
// memory read per cycle, at most MAX_PROBES+1 slots; the hit or empty slot is written
// back in the last probe cycle. An accepted item goes from IDLE (first slot read)
// through PROBE (one memory read per probed slot) to RESP, where its result waits
// until the output register takes it; only then does the sequencer return to IDLE
// and accept the next item. A zero key goes from IDLE straight to RESP.
// Reset: the sequencer sweeps the slot memory writing empty keys, one slot a cycle,
// so in_stall_o stays high after reset is released until the last slot is cleared.
// A stalled output holds its result; the next item may still be accepted and probed,
// and it waits in the sequencer until the output register frees up.
`include "assert_macros.svh"

module linear_probe_hash_map import lphm_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_PROBES    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [63:0] lookup_key_i,
  input  logic [63:0] put_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [63:0] read_value_o,
  output logic [1:0]  status_o
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Sequencer <-> memory
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  lphm_entry_t      mem_rd_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  lphm_entry_t      mem_wr_data;

  // Sequencer -> output register
  logic         res_valid;
  logic         res_take;
  lphm_result_t res;

  // Output register
  logic         out_valid_q, out_valid_d;
  lphm_result_t out_q, out_d;

  lphm_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_PROBES   (MAX_PROBES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .lookup_key_i (lookup_key_i),
    .put_value_i  (put_value_i),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res),
    .mem_rd_en_o  (mem_rd_en),
    .mem_rd_addr_o(mem_rd_addr),
    .mem_rd_data_i(mem_rd_data),
    .mem_wr_en_o  (mem_wr_en),
    .mem_wr_addr_o(mem_wr_addr),
    .mem_wr_data_o(mem_wr_data)
  );

  lphm_mem #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data)
  );

  // The output register takes a new result when empty or when its current
  // transaction completes this cycle.
  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_take) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_q.found;
  assign read_value_o = out_q.read_value;
  assign status_o     = out_q.status;

  // One item at a time: an accepted transaction closes the input until it finishes.
  `LPHM_ASSERT(a_one_in_flight, in_valid_i && !in_stall_o |=> in_stall_o)
  // Slot writes only happen while no new item can enter.
  `LPHM_ASSERT(a_wr_interlock, mem_wr_en |-> in_stall_o)
  // A result held in the sequencer is not lost or altered while the output is busy.
  `LPHM_ASSERT(a_res_hold, res_valid && !res_take |=> res_valid && $stable(res))
  // Only hits carry a value, and a hit is never an error.
  `LPHM_ASSERT(a_miss_zero, out_valid_o && !found_o |-> read_value_o == 64'd0)
  `LPHM_ASSERT(a_hit_ok, out_valid_o && found_o |-> status_o == STATUS_OK)

endmodule
